>>> rtl/pmc_pkg.sv
package pmc_pkg;

    localparam int unsigned STEP_W   = 10;
    localparam int unsigned PERIOD_W = 14;
    localparam int unsigned PULSE_W  = 20;
    localparam int unsigned CFG_W    = PULSE_W;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [STEP_W-1:0]   TICK_STEP_RESET   = STEP_W'(10);
    localparam logic [PERIOD_W-1:0] FLASH_PERIOD_RESET = PERIOD_W'(500);
    localparam logic [PULSE_W-1:0]  PULSE_DUR_RESET   = PULSE_W'(30000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_STEP    = 2'd0,
        CFG_FLASH_PERIOD = 2'd1,
        CFG_PULSE_DUR    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_CONT  = 2'd1,
        MODE_PULSE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PULSE = 2'd1,
        PEND_CONT  = 2'd2
    } t_pend;

    typedef struct packed {
        logic mode_press;
        logic confirm_press;
    } t_in_req;

    typedef struct packed {
        logic       led_red;
        logic       led_grn;
        logic       led_blu;
        logic       pump_one;
        logic       pump_two;
        logic [1:0] mode_code;
        logic [1:0] pending_code;
    } t_out_req;

    typedef struct packed {
        logic [STEP_W-1:0]   tick_step;
        logic [PERIOD_W-1:0] flash_period;
        logic [PULSE_W-1:0]  pulse_dur;
    } t_cfg;

    typedef struct packed {
        logic red;
        logic green;
        logic blue;
        logic pump_one;
        logic pump_two;
    } t_pins;

    typedef struct packed {
        t_mode               mode;
        t_pend               pend;
        logic                flashing;
        logic [PERIOD_W-1:0] flash_count;
        logic [PULSE_W-1:0]  pulse_rem;
        logic                allowed;
        t_pins               pins;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode:        MODE_IDLE,
        pend:        PEND_NONE,
        flashing:    1'b0,
        flash_count: '0,
        pulse_rem:   '0,
        allowed:     1'b1,
        pins:        '{red: 1'b0, green: 1'b1, blue: 1'b0, pump_one: 1'b0, pump_two: 1'b0}
    };

endpackage

>>> rtl/pump_mode_controller.sv
// Channel   Direction  Handshake                     Payload
// in        request    i_in_valid / o_in_stall       i_in_data  (t_in_req)
// out       result     o_out_valid / i_out_stall     o_out_data (t_out_req)
// cfg       write      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One request per cycle is sustained while the result is not stalled; a request
// passes through the input register, then the state and result register.
// The controller state is updated in the same cycle the result register loads.
// Reset is synchronous on i_rst_n low and restores the power-up pin pattern.
// A stalled result holds; one more request can wait in the input register.
module pump_mode_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pmc_pkg::t_in_req                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pmc_pkg::t_out_req                   o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pmc_pkg::CFG_W-1:0]           i_cfg_data
);

    logic              r_in_valid;
    pmc_pkg::t_in_req  r_in_data;
    logic              r_out_valid;
    pmc_pkg::t_out_req r_out_data;
    pmc_pkg::t_state   r_state;
    pmc_pkg::t_state   n_state;
    pmc_pkg::t_cfg     r_cfg;
    logic              out_open;
    logic              fire;

    assign out_open    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_open;
    assign o_in_stall  = !i_rst_n || (r_in_valid && !out_open);
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_step    <= pmc_pkg::TICK_STEP_RESET;
            r_cfg.flash_period <= pmc_pkg::FLASH_PERIOD_RESET;
            r_cfg.pulse_dur    <= pmc_pkg::PULSE_DUR_RESET;
        end else if (i_cfg_valid) begin
            case (pmc_pkg::t_cfg_idx'(i_cfg_index))
                pmc_pkg::CFG_TICK_STEP: begin
                    r_cfg.tick_step <= i_cfg_data[pmc_pkg::STEP_W-1:0];
                end
                pmc_pkg::CFG_FLASH_PERIOD: begin
                    r_cfg.flash_period <= i_cfg_data[pmc_pkg::PERIOD_W-1:0];
                end
                pmc_pkg::CFG_PULSE_DUR: begin
                    r_cfg.pulse_dur <= i_cfg_data[pmc_pkg::PULSE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    pmc_next u_next (
        .i_state (r_state),
        .i_req   (r_in_data),
        .i_cfg   (r_cfg),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmc_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (out_open) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data.led_red      <= n_state.pins.red;
            r_out_data.led_grn      <= n_state.pins.green;
            r_out_data.led_blu      <= n_state.pins.blue;
            r_out_data.pump_one     <= n_state.pins.pump_one;
            r_out_data.pump_two     <= n_state.pins.pump_two;
            r_out_data.mode_code    <= n_state.mode;
            r_out_data.pending_code <= n_state.pend;
        end
    end

endmodule

>>> rtl/pmc_next.sv
module pmc_next (
    input  pmc_pkg::t_state  i_state,
    input  pmc_pkg::t_in_req i_req,
    input  pmc_pkg::t_cfg    i_cfg,
    output pmc_pkg::t_state  o_state
);

    function automatic pmc_pkg::t_state commit(pmc_pkg::t_state s, pmc_pkg::t_mode m);
        pmc_pkg::t_state r;
        r = s;
        r.pins.red    = 1'b0;
        r.pins.green  = 1'b0;
        r.pins.blue   = 1'b0;
        r.pend        = pmc_pkg::PEND_NONE;
        r.flashing    = 1'b0;
        r.flash_count = '0;
        case (m)
            pmc_pkg::MODE_IDLE: begin
                r.pins.green    = 1'b1;
                r.pins.pump_one = 1'b0;
                r.pins.pump_two = 1'b0;
                r.allowed       = 1'b1;
            end
            pmc_pkg::MODE_CONT: begin
                r.pins.blue = 1'b1;
                if (s.allowed) begin
                    r.pins.pump_one = 1'b1;
                    r.pins.pump_two = 1'b1;
                end
            end
            default: begin
                r.pins.red      = 1'b1;
                r.pins.pump_one = 1'b0;
                r.pins.pump_two = 1'b0;
                r.pulse_rem     = '0;
            end
        endcase
        r.mode = m;
        return r;
    endfunction

    logic [pmc_pkg::PERIOD_W:0]  flash_sum;
    logic [pmc_pkg::PULSE_W-1:0] step_wide;

    assign step_wide = pmc_pkg::PULSE_W'(i_cfg.tick_step);

    always_comb begin
        o_state   = i_state;
        flash_sum = '0;

        if (i_req.mode_press) begin
            case (o_state.pend)
                pmc_pkg::PEND_NONE: begin
                    o_state.pend        = pmc_pkg::PEND_PULSE;
                    o_state.flashing    = 1'b1;
                    o_state.flash_count = '0;
                end
                pmc_pkg::PEND_PULSE: begin
                    o_state.pend        = pmc_pkg::PEND_CONT;
                    o_state.flash_count = '0;
                end
                default: begin
                    o_state = commit(o_state, pmc_pkg::MODE_IDLE);
                end
            endcase
        end

        if (i_req.confirm_press) begin
            case (o_state.pend)
                pmc_pkg::PEND_PULSE: begin
                    o_state = commit(o_state, pmc_pkg::MODE_PULSE);
                end
                pmc_pkg::PEND_CONT: begin
                    o_state = commit(o_state, pmc_pkg::MODE_CONT);
                end
                default: begin
                    // Nothing pending: confirm acts on the committed mode.
                    case (o_state.mode)
                        pmc_pkg::MODE_PULSE: begin
                            o_state.pins.pump_one = 1'b1;
                            o_state.pins.pump_two = 1'b1;
                            o_state.pulse_rem     = i_cfg.pulse_dur;
                        end
                        pmc_pkg::MODE_CONT: begin
                            o_state.allowed       = !o_state.allowed;
                            o_state.pins.pump_one = !o_state.allowed ? 1'b0 : 1'b1;
                            o_state.pins.pump_two = !o_state.allowed ? 1'b0 : 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            endcase
        end

        if (o_state.flashing) begin
            flash_sum = {1'b0, o_state.flash_count}
                      + (pmc_pkg::PERIOD_W + 1)'(i_cfg.tick_step);
            if (flash_sum >= {1'b0, i_cfg.flash_period}) begin
                o_state.flash_count = '0;
            end else begin
                o_state.flash_count = flash_sum[pmc_pkg::PERIOD_W-1:0];
            end
            if (o_state.flash_count < (i_cfg.flash_period >> 1)) begin
                o_state.pins.red   = 1'b0;
                o_state.pins.green = 1'b0;
                o_state.pins.blue  = 1'b0;
            end else if (o_state.pend == pmc_pkg::PEND_PULSE) begin
                o_state.pins.red = 1'b1;
            end else if (o_state.pend == pmc_pkg::PEND_CONT) begin
                o_state.pins.blue = 1'b1;
            end
        end

        // The countdown saturates at zero and then drops both pumps.
        if (o_state.mode == pmc_pkg::MODE_PULSE && o_state.pulse_rem != '0) begin
            if (o_state.pulse_rem > step_wide) begin
                o_state.pulse_rem = o_state.pulse_rem - step_wide;
            end else begin
                o_state.pulse_rem     = '0;
                o_state.pins.pump_one = 1'b0;
                o_state.pins.pump_two = 1'b0;
            end
        end
    end

endmodule

>>> rtl/pmc_checker.sv
module pmc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input pmc_pkg::t_out_req o_out_data
);

    // A result that waits under stall stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Both pumps are always driven together.
    a_pumps_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pump_one == o_out_data.pump_two)
        else $error("pump levels differ");

    // With no selection pending, exactly the committed mode's LED is lit.
    a_steady_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pending_code == pmc_pkg::PEND_NONE
        |-> $onehot({o_out_data.led_red, o_out_data.led_grn, o_out_data.led_blu}))
        else $error("steady LED pattern broken");

    // Settled idle shows green with both pumps off.
    a_idle_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pending_code == pmc_pkg::PEND_NONE
            && o_out_data.mode_code == pmc_pkg::MODE_IDLE
        |-> o_out_data.led_grn && !o_out_data.pump_one)
        else $error("idle pin pattern broken");

endmodule

bind pump_mode_controller pmc_checker u_pmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
